@@ rtl/card_reader_byte_store_macros.svh @@
// ----------------------------------------------------------------------------
// Card reader byte store: assertion macros
// Concurrent check wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CARD_READER_BYTE_STORE_MACROS_SVH
`define CARD_READER_BYTE_STORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk outside reset
`define CRBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds on a rising edge of clk outside reset
`define CRBS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CRBS_ASSERT(lbl, prop, msg)
`define CRBS_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/crbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Card reader byte store package
// Transfer types and fixed bus codes shared by the store modules.
// ----------------------------------------------------------------------------
package crbs_pkg;

	// Bus codes
	localparam logic [3:0]  SUBSTATE_ACTIVE = 4'd15;
	localparam logic [15:0] INSN_READ_ARM   = 16'h0A28;
	localparam logic [15:0] INSN_WRITE_BYTE = 16'h0A38;
	localparam logic [15:0] INSN_CARD_OFF   = 16'h0A48;

	// Store contents after reset
	localparam logic [7:0]  BYTE_RESET      = 8'h92;

	// Ext bus byte lane is bits 10..3
	localparam int          DATA_LSB        = 3;
	localparam int          DATA_MSB        = 10;

	typedef struct packed {
		logic [3:0]  sub_state;
		logic        write_phase;
		logic [15:0] instruction;
		logic [15:0] ext_in;
	} item_t;

	typedef struct packed {
		logic [15:0] ext_out;
		logic        card_off_pulse;
	} result_t;

	// Per-item info carried from decode into the read stage
	typedef struct packed {
		logic [15:0] ext;
		logic        pulse;
		logic        rd;
	} stage_info_t;

endpackage

@@ rtl/card_reader_byte_store.sv @@
// ----------------------------------------------------------------------------
// Card reader byte store
// Top level: bus item decode, byte store and result register.
// ----------------------------------------------------------------------------
// After reset the block fills the byte store with 0x92 in a clearing sweep and
// holds item_ready low meanwhile. From then on it takes one bus item per clock
// while stage 1 is empty or can move on into the result register; each item
// passes through stage 1 (store read) and the result register. The single store
// port serves one byte write or one byte read per item; a write is visible to the next item's read.
`include "card_reader_byte_store_macros.svh"

module card_reader_byte_store import crbs_pkg::*; #(
	parameter int CARD_BYTES = 300
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int AW = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1;

	logic          accept;
	logic          busy;
	logic          s1_adv;
	stage_info_t   info;
	stage_info_t   info_s1;
	logic          valid_s1;
	logic          out_valid_q;
	result_t       out_q;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	crbs_ctrl #(
		.CARD_BYTES(CARD_BYTES),
		.AW        (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.busy     (busy),
		.info     (info),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata)
	);

	crbs_ram #(
		.WIDTH(8),
		.DEPTH(CARD_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Handshake: stage 1 moves on when the result register is free or is being taken
	assign s1_adv     = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !busy && (!valid_s1 || s1_adv);
	assign accept     = item_valid && item_ready;

	// Stage 1 valid; read data arrives during this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold item info, merge the read byte into ext
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (s1_adv) begin
			out_q.ext_out        <= info_s1.ext |
				(info_s1.rd ? {5'b0, ram_rdata, 3'b0} : 16'h0000);
			out_q.card_off_pulse <= info_s1.pulse;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`CRBS_ASSERT(a_rise_from_s1, $rose(out_valid_q) |-> $past(valid_s1),
		"result appeared without stage 1 item")
	`CRBS_ASSERT(a_s1_hold, valid_s1 && !s1_adv |=> valid_s1,
		"stalled stage 1 item lost")

endmodule

@@ rtl/crbs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read possible per cycle at a shared address; read data registered.
// ----------------------------------------------------------------------------
module crbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 300
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                           wdata,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/crbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Card reader byte store control
// Decodes bus items, keeps the byte pointer and read flags, drives the store
// port and runs the clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "card_reader_byte_store_macros.svh"

module crbs_ctrl import crbs_pkg::*; #(
	parameter int CARD_BYTES = 300,
	parameter int AW         = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  item_t         item,
	output logic          busy,
	output stage_info_t   info,
	output logic          ram_we,
	output logic          ram_re,
	output logic [AW-1:0] ram_addr,
	output logic [7:0]    ram_wdata
);

	localparam logic [AW-1:0] LAST = AW'(CARD_BYTES - 1);

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_next;
	logic [AW-1:0] ptr_inc;
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic          rd_req_q;
	logic          rd_dly_q;
	logic          active;
	logic          do_read;
	logic          do_write;
	logic          do_off;

	// Decode the accepted transfer
	assign active   = accept && (item.sub_state == SUBSTATE_ACTIVE);
	assign do_read  = active && item.write_phase && rd_dly_q;
	assign do_write = active && !item.write_phase && (item.instruction == INSN_WRITE_BYTE);
	assign do_off   = active && !item.write_phase && (item.instruction == INSN_CARD_OFF);

	// Advance with wrap at the last byte
	assign ptr_inc = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);

	always_comb begin
		ptr_next = ptr_q;
		if (do_read || do_write) begin
			ptr_next = ptr_inc;
		end else if (do_off) begin
			ptr_next = '0;
		end
	end

	// Pointer, read flags and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			rd_req_q   <= 1'b0;
			rd_dly_q   <= 1'b0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			ptr_q <= ptr_next;
			if (active && !item.write_phase) begin
				rd_dly_q <= rd_req_q;
				rd_req_q <= (item.instruction == INSN_READ_ARM);
			end
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == LAST) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	// Store port: sweep first, then item accesses
	assign ram_we    = clearing_q || do_write;
	assign ram_re    = do_read;
	assign ram_addr  = clearing_q ? clr_addr_q : ptr_q;
	assign ram_wdata = clearing_q ? BYTE_RESET : item.ext_in[DATA_MSB:DATA_LSB];

	assign busy       = clearing_q;
	assign info.ext   = item.ext_in;
	assign info.pulse = do_off;
	assign info.rd    = do_read;

	`CRBS_ASSERT(a_ptr_range, ptr_q <= LAST, "byte pointer beyond store")
	`CRBS_NEVER(a_accept_clear, accept && clearing_q, "transfer taken during clearing sweep")
	`CRBS_NEVER(a_rw_same, ram_we && ram_re, "store read and write in one cycle")

endmodule

@@ tb/sv/card_reader_byte_store_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Card reader byte store testbench
// Offers bus states over a valid/ready channel and checks every ext/pulse
// result in order against a typed-in value or a cycle-free shadow of the store,
// pointer and read flags. Runs a directed table, then random read/write traffic
// under several sender and receiver idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module card_reader_byte_store_tb;
	import crbs_pkg::*;

	localparam int     CARD_BYTES   = 300;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     DRAIN_CYCLES = 10;
	localparam int     REPORT_LIMIT = 200;
	localparam longint CYCLE_LIMIT  = 200000;

	// One directed row: bus state, whether the result is typed in, and that result
	typedef struct packed {
		item_t   bus;
		logic    typed;
		result_t want;
	} bus_row_t;

	localparam int DIRECTED_COUNT = 21;
	localparam bus_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// arm in an idle sub-state does nothing
		{4'd0, 1'b0, INSN_READ_ARM, 16'h0000, 1'b1, 16'h0000, 1'b0},
		{4'd14, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		// arm, shift into the delay stage, then two output phases read reset bytes
		{SUBSTATE_ACTIVE, 1'b0, INSN_READ_ARM, 16'h1234, 1'b1, 16'h1234, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
		{SUBSTATE_ACTIVE, 1'b1, 16'h0000, 16'h0000, 1'b1, 16'h0490, 1'b0},
		{SUBSTATE_ACTIVE, 1'b1, 16'hFFFF, 16'h0007, 1'b1, 16'h0497, 1'b0},
		// card off pulses and rewinds; the next output phase has no read pending
		{SUBSTATE_ACTIVE, 1'b0, INSN_CARD_OFF, 16'hABCD, 1'b1, 16'hABCD, 1'b1},
		{SUBSTATE_ACTIVE, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		// write all-ones and all-zeros bytes
		{SUBSTATE_ACTIVE, 1'b0, INSN_WRITE_BYTE, 16'h07F8, 1'b1, 16'h07F8, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, INSN_WRITE_BYTE, 16'hF807, 1'b1, 16'hF807, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, INSN_CARD_OFF, 16'h0000, 1'b1, 16'h0000, 1'b1},
		// read back across an unknown instruction and an idle sub-state
		{SUBSTATE_ACTIVE, 1'b0, INSN_READ_ARM, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, 16'h0A29, 16'h5A5A, 1'b0, 16'h0000, 1'b0},
		{SUBSTATE_ACTIVE, 1'b1, 16'h0000, 16'h0000, 1'b1, 16'h07F8, 1'b0},
		{SUBSTATE_ACTIVE, 1'b1, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
		{4'd7, 1'b1, INSN_READ_ARM, 16'h5555, 1'b1, 16'h5555, 1'b0},
		{SUBSTATE_ACTIVE, 1'b1, 16'h1234, 16'h8000, 1'b1, 16'h8490, 1'b0},
		{4'd3, 1'b0, INSN_WRITE_BYTE, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		// arm then write: the delayed flag is set by the write's decode
		{SUBSTATE_ACTIVE, 1'b0, INSN_READ_ARM, 16'h0000, 1'b0, 16'h0000, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, INSN_WRITE_BYTE, 16'h2AAA, 1'b0, 16'h0000, 1'b0},
		{SUBSTATE_ACTIVE, 1'b0, INSN_CARD_OFF, 16'h0000, 1'b1, 16'h0000, 1'b1}
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   bus_item;
	logic    result_valid;
	logic    result_ready;
	result_t bus_result;

	// Shadow of the block's state
	logic [7:0] shadow_bytes [CARD_BYTES];
	logic [8:0] shadow_ptr;
	logic       shadow_arm;
	logic       shadow_arm_dly;

	result_t pending_results [$];
	logic    want_typed;
	result_t typed_result;
	int      items_taken;
	int      fail_count;
	longint  cycle_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	logic    hold_wanted;

	card_reader_byte_store #(
		.CARD_BYTES(CARD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(bus_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(bus_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [8:0] next_ptr(logic [8:0] p);
		return (p == CARD_BYTES - 1) ? 9'd0 : p + 9'd1;
	endfunction

	// Apply one bus state to the shadow and return the bus result it gives
	function automatic result_t serve_bus_state(item_t s);
		result_t r;
		r.ext_out        = s.ext_in;
		r.card_off_pulse = 1'b0;
		if (s.sub_state == SUBSTATE_ACTIVE) begin
			if (s.write_phase) begin
				if (shadow_arm_dly) begin
					r.ext_out  = s.ext_in | (16'(shadow_bytes[shadow_ptr]) << DATA_LSB);
					shadow_ptr = next_ptr(shadow_ptr);
				end
			end else begin
				shadow_arm_dly = shadow_arm;
				shadow_arm     = 1'b0;
				case (s.instruction)
					INSN_READ_ARM: shadow_arm = 1'b1;
					INSN_WRITE_BYTE: begin
						shadow_bytes[shadow_ptr] = s.ext_in[DATA_MSB:DATA_LSB];
						shadow_ptr               = next_ptr(shadow_ptr);
					end
					INSN_CARD_OFF: begin
						r.card_off_pulse = 1'b1;
						shadow_ptr       = '0;
					end
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin : bus_monitor
		result_t predicted;
		result_t wanted;
		if (arst_n && item_valid && item_ready) begin
			predicted = serve_bus_state(bus_item);
			pending_results.push_back(want_typed ? typed_result : predicted);
			items_taken++;
		end
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with none pending, ext_out=%h pulse=%b",
					bus_result.ext_out, bus_result.card_off_pulse));
			end else begin
				wanted = pending_results.pop_front();
				if (bus_result.ext_out !== wanted.ext_out)
					report_mismatch($sformatf("ext_out %h, expected %h",
						bus_result.ext_out, wanted.ext_out));
				if (bus_result.card_off_pulse !== wanted.card_off_pulse)
					report_mismatch($sformatf("card_off_pulse %b, expected %b",
						bus_result.card_off_pulse, wanted.card_off_pulse));
			end
		end
	end

	// Receiver: one long hold-off when asked, random stalls otherwise
	initial begin : receiver
		int held;
		held         = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && held < HOLD_CYCLES) begin
				result_ready = 1'b0;
				held++;
			end else begin
				result_ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one bus state after a random gap and hold it until transferred
	task automatic offer_bus_state(item_t s, logic typed, result_t want);
		int taken_before;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		bus_item     = s;
		want_typed   = typed;
		typed_result = want;
		item_valid   = 1'b1;
		taken_before = items_taken;
		do @(negedge clk); while (items_taken == taken_before);
	endtask

	// Random traffic: mostly well-formed write and read sequences
	task automatic run_random_phase(int target, int card_off_permille);
		int      acted;
		int      kind;
		item_t   s;
		result_t none;
		none  = '0;
		acted = 0;
		while (acted < target) begin
			kind          = $urandom_range(0, 999);
			s.sub_state   = SUBSTATE_ACTIVE;
			s.write_phase = 1'b0;
			s.instruction = 16'($urandom);
			s.ext_in      = 16'($urandom);
			if (kind < card_off_permille) begin
				s.instruction = INSN_CARD_OFF;
			end else if (kind < 350) begin
				s.instruction = INSN_WRITE_BYTE;
			end else if (kind < 600) begin
				// arm, one more decode, then a short run of output phases
				s.instruction = INSN_READ_ARM;
				offer_bus_state(s, 1'b0, none);
				s.instruction = ($urandom_range(0, 3) == 0) ? INSN_WRITE_BYTE : 16'($urandom);
				s.ext_in      = 16'($urandom);
				offer_bus_state(s, 1'b0, none);
				acted += 2;
				repeat ($urandom_range(1, 3)) begin
					s.write_phase = 1'b1;
					s.ext_in      = 16'($urandom);
					offer_bus_state(s, 1'b0, none);
					acted++;
				end
				continue;
			end else if (kind < 720) begin
				s.write_phase = 1'b1;
			end else if (kind < 850) begin
				s.instruction = 16'($urandom);
			end else begin
				s.sub_state   = 4'($urandom);
				s.write_phase = 1'($urandom);
			end
			offer_bus_state(s, 1'b0, none);
			if (s.sub_state == SUBSTATE_ACTIVE)
				acted++;
		end
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		bus_item       = '0;
		want_typed     = 1'b0;
		typed_result   = '0;
		items_taken    = 0;
		fail_count     = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_wanted    = 1'b0;
		for (int b = 0; b < CARD_BYTES; b++)
			shadow_bytes[b] = BYTE_RESET;
		shadow_ptr     = '0;
		shadow_arm     = 1'b0;
		shadow_arm_dly = 1'b0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed table, no idling
		for (int r = 0; r < DIRECTED_COUNT; r++)
			offer_bus_state(DIRECTED_ROWS[r].bus, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		// Full rate with a long receiver hold-off so the block backs up
		hold_wanted = 1'b1;
		run_random_phase(200, 0);

		send_idle_pct = 61;
		run_random_phase(130, 0);

		send_idle_pct  = 0;
		recv_stall_pct = 61;
		run_random_phase(130, 0);

		send_idle_pct  = 29;
		recv_stall_pct = 29;
		run_random_phase(140, 20);

		// Drain and let any stray result show up
		item_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ card_reader_byte_store.f @@
+incdir+rtl
rtl/crbs_pkg.sv
rtl/crbs_ram.sv
rtl/crbs_ctrl.sv
rtl/card_reader_byte_store.sv
tb/sv/card_reader_byte_store_tb.sv
